FILE: rtl/spqa_pkg.sv
package spqa_pkg;

    // Queue geometry and field widths
    localparam int QUEUE_DEPTH = 64;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W       = 31;
    localparam int TAG_W       = 16;
    localparam int CNT_W       = 16;
    localparam int STATUS_W    = 3;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 16'd100;
    localparam logic [CNT_W-1:0] COUNT_MAX   = 16'hFFFF;

    // Register byte offsets
    localparam logic [ADDR_W-1:0] REG_BUNKER_LIMIT = 3'd0;

    // Request codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_ADMITTED  = 3'd2,
        ST_DISCARDED = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } cell_cmd_t;

endpackage

FILE: rtl/spqa_cell.sv
module spqa_cell
    import spqa_pkg::*;
(
    input  logic             aclk,
    input  cell_cmd_t        cmd,
    input  logic             valid_i,
    input  logic             prev_ge,
    input  logic [KEY_W-1:0] prev_key,
    input  logic [TAG_W-1:0] prev_tag,
    input  logic [KEY_W-1:0] next_key,
    input  logic [TAG_W-1:0] next_tag,
    output logic             ge,
    output logic [KEY_W-1:0] key_o,
    output logic [TAG_W-1:0] tag_o
);

    logic [KEY_W-1:0] key_reg, key_next;
    logic [TAG_W-1:0] tag_reg, tag_next;

    // The held entry stays ahead of a new one when its key is equal or greater.
    assign ge = valid_i && (key_reg >= cmd.key);

    // On insert the cell keeps, takes the new entry, or takes its upper
    // neighbour's entry; on remove it takes its lower neighbour's entry.
    always_comb begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (cmd.ins) begin
            if (!ge) begin
                if (prev_ge) begin
                    key_next = cmd.key;
                    tag_next = cmd.tag;
                end else begin
                    key_next = prev_key;
                    tag_next = prev_tag;
                end
            end
        end else if (cmd.rem) begin
            key_next = next_key;
            tag_next = next_tag;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key_o = key_reg;
    assign tag_o = tag_reg;

endmodule

FILE: rtl/stable_priority_queue_admit.sv
// A result is presented in the cycle after its request transfer. One request
// per cycle unless the result channel stalls; every cell of the sorted chain
// decides its move in parallel from the broadcast key and hands data to a
// neighbour. Reset (aresetn low at a clock edge) empties the queue, clears
// both counts and sets bunker_limit to 100; the cell contents are not cleared.
module stable_priority_queue_admit
    import spqa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic [KEY_W-1:0]    s_key,
    input  logic [TAG_W-1:0]    s_tag,
    // Result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [KEY_W-1:0]    m_out_key,
    output logic [TAG_W-1:0]    m_out_tag,
    output logic [CNT_W-1:0]    m_admitted_count,
    output logic [CNT_W-1:0]    m_unsafe_count,
    output logic [OCC_W-1:0]    m_waiting_count,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    logic [CNT_W-1:0] limit_reg;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] admitted_reg, admitted_next;
    logic [CNT_W-1:0] unsafe_reg, unsafe_next;

    logic                m_valid_reg;
    status_t             status_reg, status_next;
    logic [KEY_W-1:0]    okey_reg, okey_next;
    logic [TAG_W-1:0]    otag_reg, otag_next;

    logic       accept, is_ins, full, empty, admit;
    cell_cmd_t  cmd;

    logic             ge   [QUEUE_DEPTH];
    logic             cval [QUEUE_DEPTH];
    logic [KEY_W-1:0] ckey [QUEUE_DEPTH];
    logic [TAG_W-1:0] ctag [QUEUE_DEPTH];

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BUNKER_LIMIT[2]) ? {{(DATA_W-CNT_W){1'b0}}, limit_reg}
                                                      : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_BUNKER_LIMIT[2]) begin
            limit_reg <= pwdata[CNT_W-1:0];
        end
    end

    // Request decode; a new request transfers while the result slot drains
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_ins  = (s_opcode == OP_INSERT);
    assign full    = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign empty   = (occ_reg == '0);
    assign admit   = (admitted_reg < limit_reg);

    assign cmd.ins = accept && is_ins && !full;
    assign cmd.rem = accept && !is_ins && !empty;
    assign cmd.key = s_key;
    assign cmd.tag = s_tag;

    // Chain of cells, head at index zero
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic             p_ge;
        logic [KEY_W-1:0] p_key, n_key;
        logic [TAG_W-1:0] p_tag, n_tag;

        assign cval[g] = (occ_reg > OCC_W'(g));

        if (g == 0) begin : g_head
            assign p_ge  = 1'b1;
            assign p_key = s_key;
            assign p_tag = s_tag;
        end else begin : g_body
            assign p_ge  = ge[g-1];
            assign p_key = ckey[g-1];
            assign p_tag = ctag[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign n_key = s_key;
            assign n_tag = s_tag;
        end else begin : g_inner
            assign n_key = ckey[g+1];
            assign n_tag = ctag[g+1];
        end

        spqa_cell u_cell (
            .aclk     (aclk),
            .cmd      (cmd),
            .valid_i  (cval[g]),
            .prev_ge  (p_ge),
            .prev_key (p_key),
            .prev_tag (p_tag),
            .next_key (n_key),
            .next_tag (n_tag),
            .ge       (ge[g]),
            .key_o    (ckey[g]),
            .tag_o    (ctag[g])
        );
    end

    // Counters and the result of the request
    always_comb begin
        occ_next      = occ_reg;
        admitted_next = admitted_reg;
        unsafe_next   = unsafe_reg;
        okey_next     = '0;
        otag_next     = '0;
        status_next   = ST_INSERTED;
        if (is_ins) begin
            if (full) begin
                status_next = ST_FULL;
            end else begin
                occ_next = occ_reg + OCC_W'(1);
                if (unsafe_reg != COUNT_MAX) begin
                    unsafe_next = unsafe_reg + CNT_W'(1);
                end
            end
        end else begin
            if (empty) begin
                status_next = ST_EMPTY;
            end else begin
                okey_next = ckey[0];
                otag_next = ctag[0];
                occ_next  = occ_reg - OCC_W'(1);
                if (admit) begin
                    status_next = ST_ADMITTED;
                    if (admitted_reg != COUNT_MAX) begin
                        admitted_next = admitted_reg + CNT_W'(1);
                    end
                    if (unsafe_reg != '0) begin
                        unsafe_next = unsafe_reg - CNT_W'(1);
                    end
                end else begin
                    status_next = ST_DISCARDED;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg      <= '0;
            admitted_reg <= '0;
            unsafe_reg   <= '0;
        end else if (accept) begin
            occ_reg      <= occ_next;
            admitted_reg <= admitted_next;
            unsafe_reg   <= unsafe_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            okey_reg   <= okey_next;
            otag_reg   <= otag_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_out_key        = okey_reg;
    assign m_out_tag        = otag_reg;
    assign m_admitted_count = admitted_reg;
    assign m_unsafe_count   = unsafe_reg;
    assign m_waiting_count  = occ_reg;

    // Checks
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("request taken while a result is stalled");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins |=> (occ_reg == $past(occ_reg) + OCC_W'(1)))
        else $error("insert did not grow the queue");

    a_admit_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg == ST_ADMITTED) |-> (admitted_reg != '0))
        else $error("admission reported with zero admitted count");

endmodule
